// File: hdl/mbpe_pkg.sv
package mbpe_pkg;

  // Command codes carried on the command field.
  localparam logic [2:0] CMD_RD_COILS = 3'd0;
  localparam logic [2:0] CMD_RD_REGS  = 3'd1;
  localparam logic [2:0] CMD_WR_COIL  = 3'd2;
  localparam logic [2:0] CMD_WR_REG   = 3'd3;
  localparam logic [2:0] CMD_WR_COILS = 3'd4;
  localparam logic [2:0] CMD_WR_REGS  = 3'd5;
  localparam logic [2:0] CMD_DATA     = 3'd6;

  // Modbus function codes.
  localparam logic [7:0] FC_RD_COILS = 8'h01;
  localparam logic [7:0] FC_RD_REGS  = 8'h03;
  localparam logic [7:0] FC_WR_COIL  = 8'h05;
  localparam logic [7:0] FC_WR_REG   = 8'h06;
  localparam logic [7:0] FC_WR_COILS = 8'h0F;
  localparam logic [7:0] FC_WR_REGS  = 8'h10;

  // Single coil values as sent on the wire.
  localparam logic [15:0] COIL_ON  = 16'hFF00;
  localparam logic [15:0] COIL_OFF = 16'h0000;

  // Protocol limits on counts.
  localparam logic [15:0] MAX_READ_COILS      = 16'd2000;
  localparam logic [15:0] MAX_READ_REGISTERS  = 16'd125;
  localparam logic [15:0] MAX_WRITE_COILS     = 16'd1968;
  localparam logic [15:0] MAX_WRITE_REGISTERS = 16'd123;

  // Status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_PARAM  = 2'd1;
  localparam logic [1:0] ST_UNEXPECTED = 2'd2;

  // Open write modes.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_COILS = 2'd1;
  localparam logic [1:0] MODE_REGS  = 2'd2;

  localparam int JOB_BYTES = 6;

  // One unit of output work: up to six bytes sent in order from index zero.
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      final_last;
    logic                      byte_valid;
    logic [1:0]                status;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_push_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

endpackage

// File: hdl/mbpe_front.sv
module mbpe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        command,
  input  logic [15:0]       address,
  input  logic [15:0]       quantity,
  input  logic [15:0]       data_value,
  input  logic              q_full,
  output mbpe_pkg::q_push_t q_push
);
  import mbpe_pkg::*;

  logic [1:0]  mode;
  logic [1:0]  mode_next;
  logic [10:0] left;
  logic [10:0] left_next;
  logic [7:0]  acc;
  logic [7:0]  acc_next;
  logic [2:0]  bp;
  logic [2:0]  bp_next;
  logic        accept;
  logic [10:0] left_dec;
  logic [7:0]  acc_or;
  logic [15:0] nbytes_coils;
  logic        push;
  job_t        job;

  function automatic job_t make_status(input logic [1:0] st);
    job_t j;
    j            = '0;
    j.count      = 3'd1;
    j.final_last = 1'b1;
    j.byte_valid = 1'b0;
    j.status     = st;
    return j;
  endfunction

  function automatic job_t make_five(input logic [7:0] fc, input logic [15:0] addr,
                                     input logic [15:0] val);
    job_t j;
    j            = '0;
    j.bytes[0]   = fc;
    j.bytes[1]   = addr[15:8];
    j.bytes[2]   = addr[7:0];
    j.bytes[3]   = val[15:8];
    j.bytes[4]   = val[7:0];
    j.count      = 3'd5;
    j.final_last = 1'b1;
    j.byte_valid = 1'b1;
    j.status     = ST_OK;
    return j;
  endfunction

  function automatic job_t make_header(input logic [7:0] fc, input logic [15:0] addr,
                                       input logic [15:0] qty, input logic [7:0] nb);
    job_t j;
    j            = make_five(fc, addr, qty);
    j.bytes[5]   = nb;
    j.count      = 3'd6;
    j.final_last = 1'b0;
    return j;
  endfunction

  // The queue has room for any single transaction's work.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign left_dec     = left - 11'd1;
  assign acc_or       = acc | (8'(data_value[0]) << bp);
  assign nbytes_coils = (quantity + 16'd7) >> 3;

  // Classify the item against the open-write state and build its job.
  always_comb begin
    push      = 1'b0;
    job       = '0;
    mode_next = mode;
    left_next = left;
    acc_next  = acc;
    bp_next   = bp;
    if (command == CMD_DATA) begin
      unique case (mode)
        MODE_COILS: begin
          left_next = left_dec;
          if (bp == 3'd7 || left_dec == 11'd0) begin
            push             = 1'b1;
            job              = make_status(ST_OK);
            job.bytes[0]     = acc_or;
            job.byte_valid   = 1'b1;
            job.final_last   = (left_dec == 11'd0);
            acc_next         = '0;
            bp_next          = '0;
            if (left_dec == 11'd0) begin
              mode_next = MODE_IDLE;
            end
          end else begin
            acc_next = acc_or;
            bp_next  = bp + 3'd1;
          end
        end
        MODE_REGS: begin
          left_next      = left_dec;
          push           = 1'b1;
          job            = make_status(ST_OK);
          job.bytes[0]   = data_value[15:8];
          job.bytes[1]   = data_value[7:0];
          job.count      = 3'd2;
          job.byte_valid = 1'b1;
          job.final_last = (left_dec == 11'd0);
          if (left_dec == 11'd0) begin
            mode_next = MODE_IDLE;
          end
        end
        default: begin
          push = 1'b1;
          job  = make_status(ST_UNEXPECTED);
        end
      endcase
    end else if (mode != MODE_IDLE) begin
      push = 1'b1;
      job  = make_status(ST_UNEXPECTED);
    end else begin
      push = 1'b1;
      unique case (command)
        CMD_RD_COILS: begin
          if (quantity == 16'd0 || quantity > MAX_READ_COILS) begin
            job = make_status(ST_BAD_PARAM);
          end else begin
            job = make_five(FC_RD_COILS, address, quantity);
          end
        end
        CMD_RD_REGS: begin
          if (quantity == 16'd0 || quantity > MAX_READ_REGISTERS) begin
            job = make_status(ST_BAD_PARAM);
          end else begin
            job = make_five(FC_RD_REGS, address, quantity);
          end
        end
        CMD_WR_COIL: begin
          job = make_five(FC_WR_COIL, address, (quantity != 16'd0) ? COIL_ON : COIL_OFF);
        end
        CMD_WR_REG: begin
          job = make_five(FC_WR_REG, address, quantity);
        end
        CMD_WR_COILS: begin
          if (quantity == 16'd0 || quantity > MAX_WRITE_COILS) begin
            job = make_status(ST_BAD_PARAM);
          end else begin
            job       = make_header(FC_WR_COILS, address, quantity, nbytes_coils[7:0]);
            mode_next = MODE_COILS;
            left_next = quantity[10:0];
            acc_next  = '0;
            bp_next   = '0;
          end
        end
        CMD_WR_REGS: begin
          if (quantity == 16'd0 || quantity > MAX_WRITE_REGISTERS) begin
            job = make_status(ST_BAD_PARAM);
          end else begin
            job       = make_header(FC_WR_REGS, address, quantity, {quantity[6:0], 1'b0});
            mode_next = MODE_REGS;
            left_next = quantity[10:0];
            acc_next  = '0;
            bp_next   = '0;
          end
        end
        default: begin
          job = make_status(ST_BAD_PARAM);
        end
      endcase
    end
  end

  assign q_push.push = accept && push;
  assign q_push.job  = job;

  // Open-write state advances only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      left <= '0;
      acc  <= '0;
      bp   <= '0;
    end else if (accept) begin
      mode <= mode_next;
      left <= left_next;
      acc  <= acc_next;
      bp   <= bp_next;
    end
  end

  // An open write always has items outstanding.
  assert property (@(posedge clk) disable iff (rst) (mode != MODE_IDLE) |-> (left != 11'd0))
    else $error("open write with no items left");

  // Coil packing state is clear whenever no coil write is open.
  assert property (@(posedge clk) disable iff (rst)
                   (mode != MODE_COILS) |-> (acc == 8'd0 && bp == 3'd0))
    else $error("stale coil packing state");

endmodule

// File: hdl/mbpe_queue.sv
module mbpe_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  mbpe_pkg::q_push_t push_in,
  input  logic              pop,
  output mbpe_pkg::q_head_t head,
  output logic              full
);
  import mbpe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full       = (fill == CNT_W'(DEPTH));
  assign head.valid = (fill != '0);
  assign head.job   = slots[rd_ptr];
  assign do_push    = push_in.push && !full;
  assign do_pop     = pop && head.valid;

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_in.job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  // The front must never offer a job to a full queue.
  assert property (@(posedge clk) disable iff (rst) push_in.push |-> !full)
    else $error("push into full queue");

endmodule

// File: hdl/mbpe_back.sv
module mbpe_back (
  input  logic              clk,
  input  logic              rst,
  input  mbpe_pkg::q_head_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              byte_valid,
  output logic              last,
  output logic [1:0]        status
);
  import mbpe_pkg::*;

  logic [2:0] idx;
  logic       load;
  logic       final_byte;

  assign load       = head.valid && (!out_valid || !out_stall);
  assign final_byte = (idx == head.job.count - 3'd1);
  assign pop        = load && final_byte;

  // Walk through the head job one byte per cycle while the output register can load.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= final_byte ? 3'd0 : idx + 3'd1;
    end
  end

  // Output register; it takes a new byte when one is waiting and it is empty or the consumer is not stalling.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= head.job.bytes[idx];
      byte_valid <= head.job.byte_valid;
      last       <= final_byte && head.job.final_last;
      status     <= head.job.status;
    end
  end

  // The byte index stays inside the job at the head of the queue.
  assert property (@(posedge clk) disable iff (rst) head.valid |-> (idx < head.job.count))
    else $error("byte index beyond job");

  // A status transaction is always the last of its group.
  assert property (@(posedge clk) disable iff (rst) (out_valid && !byte_valid) |-> last)
    else $error("status transaction without last");

endmodule

// File: hdl/modbus_request_pdu_encoder.sv
// Modbus request PDU encoder. Each accepted command or data transaction is
// classified at once and its output bytes are queued; the back end sends one
// byte per cycle on the output channel while out_stall is low. A read or
// single-write command yields five bytes, a multi-write header six, a register
// data item two, a coil data item one byte per eight items or at the end of the
// write, and any rejected item one status transaction with byte_valid low. The
// input side accepts a transaction every cycle while the job queue has room, so
// sustained throughput is set by the one-byte-per-cycle output register, and
// QUEUE_DEPTH sets how many jobs the input can run ahead of the output. With
// the queue empty, the first byte of an item passes from the job queue into
// the output register, which presents it on the output.
module modbus_request_pdu_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [15:0] address,
  input  logic [15:0] quantity,
  input  logic [15:0] data_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last,
  output logic [1:0]  status
);
  import mbpe_pkg::*;

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  mbpe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .address    (address),
    .quantity   (quantity),
    .data_value (data_value),
    .q_full     (q_full),
    .q_push     (q_push)
  );

  mbpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_in (q_push),
    .pop     (q_pop),
    .head    (q_head),
    .full    (q_full)
  );

  mbpe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .status     (status)
  );

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbpe_pkg::*;

  // Command code seven has no meaning for the block.
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 400;
  localparam int CALM_ITEMS = 80;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int LIMIT_CYCLES = 1500000;

  // One output transaction as seen on the result channel.
  typedef struct packed {
    logic [7:0] pdu_byte;
    logic       carries_byte;
    logic       is_last;
    logic [1:0] code;
  } pdu_out_t;

  // One row of the directed stimulus; a typed row expects a single status transaction.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] addr;
    logic [15:0] qty;
    logic [15:0] dval;
    logic        typed;
    logic [1:0]  want_st;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  command;
  logic [15:0] address;
  logic [15:0] quantity;
  logic [15:0] data_value;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [1:0]  status;

  // Shadow of the encoder state.
  logic [1:0]  wr_mode;
  logic [10:0] items_due;
  logic [7:0]  coil_bits;
  logic [3:0]  coil_pos;

  pdu_out_t step_out [JOB_BYTES];
  pdu_out_t pending_pdu [$];
  int       fail_count = 0;
  int       cycle_count = 0;
  bit       calm = 1'b0;
  bit       hold_req = 1'b0;

  modbus_request_pdu_encoder uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .address    (address),
    .quantity   (quantity),
    .data_value (data_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .status     (status)
  );

  always #2 clk = ~clk;

  function automatic void put_byte(input int k, input logic [7:0] b, input logic bv,
                                   input logic lst, input logic [1:0] st);
    step_out[k] = '{pdu_byte: b, carries_byte: bv, is_last: lst, code: st};
  endfunction

  // Function code, address and a 16-bit word, all big-endian.
  function automatic void put_frame(input logic [7:0] fc, input logic [15:0] addr,
                                    input logic [15:0] word, input logic lst);
    put_byte(0, fc, 1'b1, 1'b0, ST_OK);
    put_byte(1, addr[15:8], 1'b1, 1'b0, ST_OK);
    put_byte(2, addr[7:0], 1'b1, 1'b0, ST_OK);
    put_byte(3, word[15:8], 1'b1, 1'b0, ST_OK);
    put_byte(4, word[7:0], 1'b1, lst, ST_OK);
  endfunction

  // Works out the bytes one accepted transaction produces and advances the shadow state.
  function automatic int encode_request(input logic [2:0] cmd, input logic [15:0] addr,
                                        input logic [15:0] qty, input logic [15:0] dval);
    logic [7:0]  fc;
    logic [15:0] limit;
    logic [15:0] word;
    int          nbytes;
    fc = 8'h00;
    limit = 16'd0;
    if (cmd == CMD_DATA) begin
      if (wr_mode == MODE_COILS) begin
        coil_bits = coil_bits | (8'(dval[0]) << coil_pos[2:0]);
        coil_pos = coil_pos + 4'd1;
        items_due = items_due - 11'd1;
        if (coil_pos >= 4'd8 || items_due == 11'd0) begin
          put_byte(0, coil_bits, 1'b1, items_due == 11'd0, ST_OK);
          coil_bits = 8'h00;
          coil_pos = 4'd0;
          if (items_due == 11'd0) wr_mode = MODE_IDLE;
          return 1;
        end
        return 0;
      end
      if (wr_mode == MODE_REGS) begin
        items_due = items_due - 11'd1;
        put_byte(0, dval[15:8], 1'b1, 1'b0, ST_OK);
        put_byte(1, dval[7:0], 1'b1, items_due == 11'd0, ST_OK);
        if (items_due == 11'd0) wr_mode = MODE_IDLE;
        return 2;
      end
      put_byte(0, 8'h00, 1'b0, 1'b1, ST_UNEXPECTED);
      return 1;
    end
    if (wr_mode != MODE_IDLE) begin
      put_byte(0, 8'h00, 1'b0, 1'b1, ST_UNEXPECTED);
      return 1;
    end
    case (cmd)
      CMD_RD_COILS: begin
        fc = FC_RD_COILS;
        limit = MAX_READ_COILS;
      end
      CMD_RD_REGS: begin
        fc = FC_RD_REGS;
        limit = MAX_READ_REGISTERS;
      end
      CMD_WR_COIL: fc = FC_WR_COIL;
      CMD_WR_REG: fc = FC_WR_REG;
      CMD_WR_COILS: begin
        fc = FC_WR_COILS;
        limit = MAX_WRITE_COILS;
      end
      CMD_WR_REGS: begin
        fc = FC_WR_REGS;
        limit = MAX_WRITE_REGISTERS;
      end
      default: begin
        put_byte(0, 8'h00, 1'b0, 1'b1, ST_BAD_PARAM);
        return 1;
      end
    endcase
    // Counts are range checked; single writes take any value.
    if (limit != 16'd0 && (qty == 16'd0 || qty > limit)) begin
      put_byte(0, 8'h00, 1'b0, 1'b1, ST_BAD_PARAM);
      return 1;
    end
    if (cmd == CMD_WR_COIL) word = (qty != 16'd0) ? COIL_ON : COIL_OFF;
    else word = qty;
    if (cmd != CMD_WR_COILS && cmd != CMD_WR_REGS) begin
      put_frame(fc, addr, word, 1'b1);
      return 5;
    end
    // A multi-write header carries the byte count and opens the write.
    nbytes = (cmd == CMD_WR_COILS) ? (int'(qty) + 7) / 8 : int'(qty) * 2;
    put_frame(fc, addr, word, 1'b0);
    put_byte(5, nbytes[7:0], 1'b1, 1'b0, ST_OK);
    wr_mode = (cmd == CMD_WR_COILS) ? MODE_COILS : MODE_REGS;
    items_due = qty[10:0];
    coil_bits = 8'h00;
    coil_pos = 4'd0;
    return 6;
  endfunction

  // Offers one transaction, entered and left at a falling edge.
  task automatic offer_item(input logic [2:0] cmd, input logic [15:0] addr,
                            input logic [15:0] qty, input logic [15:0] dval,
                            input logic typed, input logic [1:0] want_st);
    int       n;
    pdu_out_t stat_item;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    address    <= addr;
    quantity   <= qty;
    data_value <= dval;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = encode_request(cmd, addr, qty, dval);
    if (typed) begin
      stat_item = '{pdu_byte: 8'h00, carries_byte: 1'b0, is_last: 1'b1, code: want_st};
      pending_pdu.insert(pending_pdu.size(), stat_item);
    end else begin
      for (int k = 0; k < n; k++) pending_pdu.insert(pending_pdu.size(), step_out[k]);
    end
    @(negedge clk);
  endtask

  // Sender goes quiet until every outstanding byte has come out.
  task automatic drain_output();
    in_valid <= 1'b0;
    while (pending_pdu.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // A multi-write header followed by its data, with the odd stray command mixed in.
  task automatic write_burst(input logic [2:0] cmd, input logic [15:0] qty, output int sent);
    logic [15:0] limit;
    logic [2:0]  stray;
    int          n_data;
    limit = (cmd == CMD_WR_COILS) ? MAX_WRITE_COILS : MAX_WRITE_REGISTERS;
    n_data = (qty == 16'd0 || qty > limit) ? $urandom_range(1, 3) : int'(qty);
    offer_item(cmd, 16'($urandom), qty, 16'($urandom), 1'b0, ST_OK);
    sent = 1;
    for (int i = 0; i < n_data; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        stray = 3'($urandom_range(0, 6));
        if (stray == CMD_DATA) stray = CMD_UNUSED;
        offer_item(stray, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0, ST_OK);
        sent++;
      end
      offer_item(CMD_DATA, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0, ST_OK);
      sent++;
    end
  endtask

  // Picks a count near the edges of the allowed range now and then.
  function automatic logic [15:0] pick_count(input logic [15:0] limit);
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd1;
      2: return limit;
      3: return limit + 16'd1;
      4: return 16'($urandom);
      default: return 16'($urandom_range(1, int'(limit)));
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] got,
                                      input logic [7:0] want);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Result side: compare each accepted transaction with the oldest prediction.
  always @(posedge clk) begin : out_check
    pdu_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pdu.size() == 0) begin
        $display("%0t ns: unexpected output, expected none, %s %0h valid %0b last %0b status %0d",
                 $time, "actual byte", out_byte, byte_valid, last, status);
        fail_count++;
      end else begin
        want = pending_pdu.pop_front();
        check_field("out_byte", out_byte, want.pdu_byte);
        check_field("byte_valid", 8'(byte_valid), 8'(want.carries_byte));
        check_field("last", 8'(last), 8'(want.is_last));
        check_field("status", 8'(status), 8'(want.code));
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    stim_row_t   dir_rows [26];
    logic [2:0]  cmd;
    logic [15:0] qty;
    int          n_rand;
    int          seq;
    int          sent;
    int          pick;

    rst        = 1'b1;
    in_valid   = 1'b0;
    command    = CMD_RD_COILS;
    address    = 16'h0000;
    quantity   = 16'h0000;
    data_value = 16'h0000;
    wr_mode    = MODE_IDLE;
    items_due  = 11'd0;
    coil_bits  = 8'h00;
    coil_pos   = 4'd0;

    // Directed rows: errors, count extremes, every request, and an open coil write
    // interrupted by stray commands.
    dir_rows = '{
      '{CMD_DATA,     16'h0000, 16'd0,    16'h0001, 1'b1, ST_UNEXPECTED},
      '{CMD_RD_COILS, 16'h0000, 16'd0,    16'h0000, 1'b1, ST_BAD_PARAM},
      '{CMD_RD_COILS, 16'h1234, 16'd2001, 16'h0000, 1'b1, ST_BAD_PARAM},
      '{CMD_RD_COILS, 16'hFFFF, 16'd2000, 16'hFFFF, 1'b0, ST_OK},
      '{CMD_RD_REGS,  16'h8000, 16'd126,  16'h0000, 1'b1, ST_BAD_PARAM},
      '{CMD_RD_REGS,  16'h7FFF, 16'd125,  16'h0000, 1'b0, ST_OK},
      '{CMD_WR_COIL,  16'h00FF, 16'h0000, 16'h0000, 1'b0, ST_OK},
      '{CMD_WR_COIL,  16'hFF00, 16'h0001, 16'h0000, 1'b0, ST_OK},
      '{CMD_WR_REG,   16'hAAAA, 16'hFFFF, 16'h0000, 1'b0, ST_OK},
      '{CMD_UNUSED,   16'h0000, 16'd1,    16'h0000, 1'b1, ST_BAD_PARAM},
      '{CMD_WR_COILS, 16'h0000, 16'd1969, 16'h0000, 1'b1, ST_BAD_PARAM},
      '{CMD_WR_REGS,  16'h0000, 16'd0,    16'h0000, 1'b1, ST_BAD_PARAM},
      '{CMD_WR_REGS,  16'h5555, 16'd1,    16'h0000, 1'b0, ST_OK},
      '{CMD_DATA,     16'h0000, 16'd0,    16'hFFFF, 1'b0, ST_OK},
      '{CMD_WR_COILS, 16'h0102, 16'd9,    16'h0000, 1'b0, ST_OK},
      '{CMD_DATA,     16'h0000, 16'd0,    16'h0001, 1'b0, ST_OK},
      '{CMD_DATA,     16'h0000, 16'd0,    16'hFFFE, 1'b0, ST_OK},
      '{CMD_DATA,     16'h0000, 16'd0,    16'hFFFF, 1'b0, ST_OK},
      '{CMD_DATA,     16'h0000, 16'd0,    16'h0000, 1'b0, ST_OK},
      '{CMD_RD_COILS, 16'h0000, 16'd1,    16'h0000, 1'b1, ST_UNEXPECTED},
      '{CMD_UNUSED,   16'h0000, 16'd1,    16'h0000, 1'b1, ST_UNEXPECTED},
      '{CMD_DATA,     16'h0000, 16'd0,    16'h0001, 1'b0, ST_OK},
      '{CMD_DATA,     16'h0000, 16'd0,    16'h8000, 1'b0, ST_OK},
      '{CMD_DATA,     16'h0000, 16'd0,    16'h0003, 1'b0, ST_OK},
      '{CMD_DATA,     16'h0000, 16'd0,    16'h0001, 1'b0, ST_OK},
      '{CMD_DATA,     16'h0000, 16'd0,    16'h7FFF, 1'b0, ST_OK}
    };

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      offer_item(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].qty, dir_rows[i].dval,
                 dir_rows[i].typed, dir_rows[i].want_st);
    end
    drain_output();

    // Random part: mostly complete multi-writes, then single requests and noise.
    n_rand = 0;
    seq = 0;
    while (n_rand < RANDOM_ITEMS) begin
      if (n_rand >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (seq == 2) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (seq == 4) begin
        write_burst(CMD_WR_REGS, MAX_WRITE_REGISTERS, sent);
        n_rand += sent;
      end else if (seq == 9) begin
        // A coil write whose final byte is only partly filled.
        write_burst(CMD_WR_COILS, 16'd61, sent);
        n_rand += sent;
      end else if (pick < 55) begin
        cmd = ($urandom_range(0, 1) == 0) ? CMD_WR_COILS : CMD_WR_REGS;
        case ($urandom_range(0, 19))
          0: qty = 16'd0;
          1: qty = (cmd == CMD_WR_COILS) ? MAX_WRITE_COILS + 16'd1 : MAX_WRITE_REGISTERS + 16'd1;
          2: qty = 16'($urandom_range(2000, 65535));
          default: qty = 16'($urandom_range(1, 40));
        endcase
        write_burst(cmd, qty, sent);
        n_rand += sent;
      end else if (pick < 85) begin
        cmd = 3'($urandom_range(0, 3));
        if (cmd == CMD_RD_COILS) qty = pick_count(MAX_READ_COILS);
        else if (cmd == CMD_RD_REGS) qty = pick_count(MAX_READ_REGISTERS);
        else qty = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        offer_item(cmd, 16'($urandom), qty, 16'($urandom), 1'b0, ST_OK);
        n_rand++;
      end else begin
        // Noise never opens a write: multi-write counts are kept out of range.
        cmd = 3'($urandom_range(0, 7));
        qty = 16'($urandom);
        if (cmd == CMD_WR_COILS || cmd == CMD_WR_REGS) qty = 16'($urandom_range(2000, 65535));
        offer_item(cmd, 16'($urandom), qty, 16'($urandom), 1'b0, ST_OK);
        n_rand++;
      end
      if (seq == 12) drain_output();
      seq++;
    end

    in_valid <= 1'b0;
    while (pending_pdu.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
